### hdl/oriented_box_from_slope_unit_macros.svh
// ----------------------------------------------------------------------------
// oriented_box_from_slope_unit_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_FROM_SLOPE_UNIT_MACROS_SVH
`define ORIENTED_BOX_FROM_SLOPE_UNIT_MACROS_SVH

// property checked outside reset
`define OBFS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define OBFS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/obfs_pkg.sv
// ----------------------------------------------------------------------------
// obfs_pkg
// Types, constants and helpers of the oriented box unit.
// ----------------------------------------------------------------------------
`default_nettype none

package obfs_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 48;
  localparam int ACCX_W  = ACC_W + 1;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int DEN_W   = COORD_W + 1;
  localparam int DVD_W   = ACC_W + FRAC_W;
  localparam int OVF_SH  = COORD_W - 1 - FRAC_W;
  localparam int CNT_W   = $clog2(DEN_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERT  = 2'd1;

  localparam logic [1:0] CRN0 = 2'd0;
  localparam logic [1:0] CRN1 = 2'd1;
  localparam logic [1:0] CRN2 = 2'd2;
  localparam logic [1:0] CRN3 = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_MUL_ALNG = 4'd2;
  localparam logic [3:0] OP_MUL_ACRS = 4'd3;
  localparam logic [3:0] OP_UPDATE   = 4'd4;
  localparam logic [3:0] OP_KP_START = 4'd5;
  localparam logic [3:0] OP_KP_STORE = 4'd6;
  localparam logic [3:0] OP_AX_OUT   = 4'd7;
  localparam logic [3:0] OP_C_SET    = 4'd8;
  localparam logic [3:0] OP_C_CHK    = 4'd9;
  localparam logic [3:0] OP_C_DIV    = 4'd10;
  localparam logic [3:0] OP_CX_STORE = 4'd11;
  localparam logic [3:0] OP_CY_MUL   = 4'd12;
  localparam logic [3:0] OP_C_OUT    = 4'd13;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] corner_x;
    logic signed [COORD_W-1:0] corner_y;
    logic [1:0]                corner_number;
    logic                      last_corner;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic axis;
  } status_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACCX_W-1:0] v);
    logic [ACCX_W-COORD_W:0] top;
    begin
      top = v[ACCX_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
        sat_coord = v[COORD_W-1:0];
      end else if (v[ACCX_W-1]) begin
        sat_coord = COORD_MIN;
      end else begin
        sat_coord = COORD_MAX;
      end
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACCX_W-1:0] v);
    begin
      if (v[ACCX_W-1] == v[ACC_W-1]) begin
        sat_acc = v[ACC_W-1:0];
      end else if (v[ACCX_W-1]) begin
        sat_acc = ACC_MIN;
      end else begin
        sat_acc = ACC_MAX;
      end
    end
  endfunction

endpackage

`default_nettype wire

### hdl/obfs_div.sv
// ----------------------------------------------------------------------------
// obfs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module obfs_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [obfs_pkg::DVD_W-1:0]    dividend,
  input  wire logic [obfs_pkg::DEN_W-1:0]    divisor,
  output logic      [obfs_pkg::DEN_W-1:0]    quotient,
  output logic                               done
);

  logic [obfs_pkg::DEN_W:0]   rem;
  logic [obfs_pkg::DEN_W-1:0] sh;
  logic [obfs_pkg::DEN_W-1:0] dvs;
  logic [obfs_pkg::CNT_W-1:0] count;
  logic                       run;
  logic [obfs_pkg::DEN_W:0]   trial;
  logic                       fits;

  assign trial = {rem[obfs_pkg::DEN_W-1:0], sh[obfs_pkg::DEN_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        count <= obfs_pkg::CNT_W'(obfs_pkg::DEN_W);
      end else if (run) begin
        count <= count - 1'b1;
        if (count == obfs_pkg::CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= (obfs_pkg::DEN_W+1)'(dividend[obfs_pkg::DVD_W-1:obfs_pkg::DEN_W]);
      sh  <= dividend[obfs_pkg::DEN_W-1:0];
      dvs <= divisor;
    end else if (run) begin
      rem <= fits ? trial - {1'b0, dvs} : trial;
      sh  <= {sh[obfs_pkg::DEN_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### hdl/obfs_dp.sv
// ----------------------------------------------------------------------------
// obfs_dp
// Datapath: slope registers, intercept trackers, corner arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module obfs_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [obfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [obfs_pkg::COORD_W-1:0]      cfg_data,
  input  wire obfs_pkg::in_item_t                point,
  input  wire obfs_pkg::cmd_t                    cmd,
  output obfs_pkg::status_t                      status,
  output logic                                   result_valid,
  output obfs_pkg::out_item_t                    result
);

  localparam int CW = obfs_pkg::COORD_W;
  localparam int AW = obfs_pkg::ACC_W;
  localparam int XW = obfs_pkg::ACCX_W;
  localparam int FW = obfs_pkg::FRAC_W;
  localparam int PW = obfs_pkg::PROD_W;
  localparam int DW = obfs_pkg::DEN_W;
  localparam int VW = obfs_pkg::DVD_W;

  logic signed [CW-1:0] k_r, kp_r, px, py, cx;
  logic                 vert_r, plast, axis_r, first_pending;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] along_r, t_ua, t_la, t_uc, t_lc, cb;
  logic signed [XW-1:0] num_r;
  logic signed [DW-1:0] den_r;
  logic [AW-1:0]        un;
  logic [DW-1:0]        ud;
  logic                 neg;

  logic signed [XW-1:0] prod_sh;
  logic signed [AW-1:0] across_v, along_v, acr_v;
  logic signed [DW-1:0] kmk;
  logic signed [XW-1:0] nsub;
  logic signed [AW-1:0] bsel;
  logic                 den_fwd;
  logic [XW-1:0]        nmag;
  logic [DW-1:0]        kmag;
  logic                 div_start, div_done;
  logic [VW-1:0]        dividend;
  logic [DW-1:0]        divisor, q;
  logic                 ovf;
  logic signed [CW-1:0] ax_x, ax_y;

  assign prod_sh  = XW'($signed(prod[PW-1:FW]));
  assign acr_v    = obfs_pkg::sat_acc(XW'(py) - prod_sh);
  assign along_v  = axis_r ? AW'(py) : along_r;
  assign across_v = axis_r ? AW'(px) : acr_v;
  assign kmk      = DW'(k_r) - DW'(kp_r);
  assign kmag     = k_r[CW-1] ? DW'(-DW'(k_r)) : DW'(k_r);
  assign nmag     = num_r[XW-1] ? XW'(-num_r) : XW'(num_r);
  assign ovf      = un >= {ud, {obfs_pkg::OVF_SH{1'b0}}};

  always_comb begin
    nsub    = '0;
    bsel    = t_ua;
    den_fwd = 1'b1;
    case (cmd.idx)
      obfs_pkg::CRN0: begin
        nsub = XW'(t_uc) - XW'(t_ua); den_fwd = 1'b1; bsel = t_ua;
      end
      obfs_pkg::CRN1: begin
        nsub = XW'(t_la) - XW'(t_uc); den_fwd = 1'b0; bsel = t_la;
      end
      obfs_pkg::CRN2: begin
        nsub = XW'(t_lc) - XW'(t_la); den_fwd = 1'b1; bsel = t_la;
      end
      obfs_pkg::CRN3: begin
        nsub = XW'(t_ua) - XW'(t_lc); den_fwd = 1'b0; bsel = t_ua;
      end
      default: begin
        nsub = '0;
      end
    endcase
  end

  always_comb begin
    ax_x = cmd.idx[1] ? obfs_pkg::sat_coord(XW'(t_lc)) : obfs_pkg::sat_coord(XW'(t_uc));
    ax_y = (cmd.idx == obfs_pkg::CRN0 || cmd.idx == obfs_pkg::CRN3)
         ? obfs_pkg::sat_coord(XW'(t_ua)) : obfs_pkg::sat_coord(XW'(t_la));
  end

  assign div_start = (cmd.op == obfs_pkg::OP_KP_START) || (cmd.op == obfs_pkg::OP_C_DIV);
  assign dividend  = (cmd.op == obfs_pkg::OP_KP_START) ? VW'(1) << (2 * FW) : {un, {FW{1'b0}}};
  assign divisor   = (cmd.op == obfs_pkg::OP_KP_START) ? kmag : ud;

  obfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quotient (q),
    .done     (div_done)
  );

  assign status.div_done = div_done;
  assign status.last     = plast;
  assign status.axis     = axis_r;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      k_r           <= '0;
      kp_r          <= '0;
      vert_r        <= 1'b0;
      first_pending <= 1'b1;
      t_ua          <= '0;
      t_la          <= '0;
      t_uc          <= '0;
      t_lc          <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= (cmd.op == obfs_pkg::OP_AX_OUT) || (cmd.op == obfs_pkg::OP_C_OUT);
      if (cfg_we && cfg_index == obfs_pkg::REG_SLOPE) begin
        k_r <= cfg_data;
      end
      if (cfg_we && cfg_index == obfs_pkg::REG_VERT) begin
        vert_r <= cfg_data[0];
      end
      if (cmd.op == obfs_pkg::OP_KP_STORE) begin
        if (k_r == '0) begin
          kp_r <= '0;
        end else if (!k_r[CW-1]) begin
          kp_r <= (q > {1'b0, obfs_pkg::COORD_MIN}) ? obfs_pkg::COORD_MIN : -q[CW-1:0];
        end else begin
          kp_r <= (q > {1'b0, obfs_pkg::COORD_MAX}) ? obfs_pkg::COORD_MAX : q[CW-1:0];
        end
      end
      if (cmd.op == obfs_pkg::OP_UPDATE) begin
        first_pending <= plast;
        if (first_pending) begin
          t_ua <= along_v;
          t_la <= along_v;
          t_uc <= across_v;
          t_lc <= across_v;
        end else begin
          if (along_v > t_ua)  t_ua <= along_v;
          if (along_v < t_la)  t_la <= along_v;
          if (across_v > t_uc) t_uc <= across_v;
          if (across_v < t_lc) t_lc <= across_v;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      obfs_pkg::OP_LOAD: begin
        px     <= point.point_x;
        py     <= point.point_y;
        plast  <= point.last_point;
        axis_r <= vert_r || (k_r == '0);
      end
      obfs_pkg::OP_MUL_ALNG: begin
        prod <= k_r * px;
      end
      obfs_pkg::OP_MUL_ACRS: begin
        along_r <= acr_v;
        prod    <= kp_r * px;
      end
      obfs_pkg::OP_C_SET: begin
        num_r <= nsub;
        den_r <= den_fwd ? kmk : DW'(-kmk);
        cb    <= bsel;
      end
      obfs_pkg::OP_C_CHK: begin
        neg <= num_r[XW-1] ^ den_r[DW-1];
        un  <= nmag[XW-1] ? {AW{1'b1}} : nmag[AW-1:0];
        ud  <= den_r[DW-1] ? DW'(-den_r) : DW'(den_r);
      end
      obfs_pkg::OP_CX_STORE: begin
        if (ud == '0) begin
          cx <= '0;
        end else if (ovf) begin
          cx <= neg ? obfs_pkg::COORD_MIN : obfs_pkg::COORD_MAX;
        end else begin
          cx <= neg ? -q[CW-1:0] : q[CW-1:0];
        end
      end
      obfs_pkg::OP_CY_MUL: begin
        prod <= cx * k_r;
      end
      obfs_pkg::OP_C_OUT: begin
        result.corner_x      <= cx;
        result.corner_y      <= obfs_pkg::sat_coord(prod_sh + XW'(cb));
        result.corner_number <= cmd.idx;
        result.last_corner   <= cmd.idx == obfs_pkg::CRN3;
      end
      obfs_pkg::OP_AX_OUT: begin
        result.corner_x      <= ax_x;
        result.corner_y      <= ax_y;
        result.corner_number <= cmd.idx;
        result.last_corner   <= cmd.idx == obfs_pkg::CRN3;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/obfs_ctrl.sv
// ----------------------------------------------------------------------------
// obfs_ctrl
// Sequencer issuing datapath operations per point, per slope write, per corner.
// ----------------------------------------------------------------------------
`default_nettype none

module obfs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               kp_req,
  input  wire obfs_pkg::status_t  status,
  output logic                    busy,
  output obfs_pkg::cmd_t          cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_KPGO   = 4'd1;
  localparam logic [3:0] S_KPWAIT = 4'd2;
  localparam logic [3:0] S_MUL1   = 4'd3;
  localparam logic [3:0] S_MUL2   = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_AXOUT  = 4'd6;
  localparam logic [3:0] S_CSET   = 4'd7;
  localparam logic [3:0] S_CCHK   = 4'd8;
  localparam logic [3:0] S_CDIV   = 4'd9;
  localparam logic [3:0] S_CWAIT  = 4'd10;
  localparam logic [3:0] S_CMUL   = 4'd11;
  localparam logic [3:0] S_COUT   = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] cnt, cnt_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.op     = obfs_pkg::OP_NOP;
    cmd.idx    = cnt;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = obfs_pkg::OP_LOAD;
          state_next = S_MUL1;
        end else if (kp_req) begin
          state_next = S_KPGO;
        end
      end
      S_KPGO: begin
        cmd.op     = obfs_pkg::OP_KP_START;
        state_next = S_KPWAIT;
      end
      S_KPWAIT: begin
        if (status.div_done) begin
          cmd.op     = obfs_pkg::OP_KP_STORE;
          state_next = S_IDLE;
        end
      end
      S_MUL1: begin
        cmd.op     = obfs_pkg::OP_MUL_ALNG;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = obfs_pkg::OP_MUL_ACRS;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op   = obfs_pkg::OP_UPDATE;
        cnt_next = obfs_pkg::CRN0;
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (status.axis) begin
          state_next = S_AXOUT;
        end else begin
          state_next = S_CSET;
        end
      end
      S_AXOUT: begin
        cmd.op   = obfs_pkg::OP_AX_OUT;
        cnt_next = cnt + 1'b1;
        if (cnt == obfs_pkg::CRN3) state_next = S_IDLE;
      end
      S_CSET: begin
        cmd.op     = obfs_pkg::OP_C_SET;
        state_next = S_CCHK;
      end
      S_CCHK: begin
        cmd.op     = obfs_pkg::OP_C_CHK;
        state_next = S_CDIV;
      end
      S_CDIV: begin
        cmd.op     = obfs_pkg::OP_C_DIV;
        state_next = S_CWAIT;
      end
      S_CWAIT: begin
        if (status.div_done) begin
          cmd.op     = obfs_pkg::OP_CX_STORE;
          state_next = S_CMUL;
        end
      end
      S_CMUL: begin
        cmd.op     = obfs_pkg::OP_CY_MUL;
        state_next = S_COUT;
      end
      S_COUT: begin
        cmd.op     = obfs_pkg::OP_C_OUT;
        cnt_next   = cnt + 1'b1;
        state_next = (cnt == obfs_pkg::CRN3) ? S_IDLE : S_CSET;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= obfs_pkg::CRN0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

### hdl/oriented_box_from_slope_unit.sv
// ----------------------------------------------------------------------------
// oriented_box_from_slope_unit
// Bounding box of a point cluster along a configured edge slope.
//
//   channel   signals                       transfer
//   point     start, busy, point            start && !busy
//   corner    result_valid, result          result_valid, one cycle
//   config    cfg_we, cfg_index, cfg_data   cfg_we
//
// A point: load, two shared 32x32 multiplies, then the tracker update.
// A last point in axis mode puts out the four corners from the trackers;
// otherwise each corner uses the 33-step shared divider.
// A slope write holds busy while the divider forms -1/k.
// Synchronous reset; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_box_from_slope_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire obfs_pkg::in_item_t              point,
  input  wire logic                            cfg_we,
  input  wire logic [obfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [obfs_pkg::COORD_W-1:0]    cfg_data,
  output logic                                 result_valid,
  output obfs_pkg::out_item_t                  result
);

  obfs_pkg::cmd_t    cmd;
  obfs_pkg::status_t status;
  logic              kp_req;

  assign kp_req = cfg_we && (cfg_index == obfs_pkg::REG_SLOPE);

  obfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kp_req (kp_req),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  obfs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point        (point),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

### hdl/obfs_checker.sv
// ----------------------------------------------------------------------------
// obfs_checker
// Port-level checks of the oriented box unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "oriented_box_from_slope_unit_macros.svh"

module obfs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire obfs_pkg::in_item_t              point,
  input wire logic                            cfg_we,
  input wire logic [obfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [obfs_pkg::COORD_W-1:0]    cfg_data,
  input wire logic                            result_valid,
  input wire obfs_pkg::out_item_t             result
);

  `OBFS_ASSERT_ALWAYS(a_idle_after_rst, clk, rst |=> !busy && !result_valid, "not idle after reset")
  `OBFS_ASSERT(a_accept_busy, clk, rst, start && !busy |=> busy, "no busy after transfer")
  `OBFS_ASSERT(a_last_num, clk, rst, result_valid |-> (result.last_corner == (result.corner_number == obfs_pkg::CRN3)), "last corner flag mismatch")
  `OBFS_ASSERT(a_more_pending, clk, rst, result_valid && !result.last_corner |-> busy, "idle with corners pending")
  `OBFS_ASSERT(a_slope_busy, clk, rst, cfg_we && cfg_index == obfs_pkg::REG_SLOPE && !busy |=> busy, "slope write not processed")

endmodule

bind oriented_box_from_slope_unit obfs_checker u_obfs_checker (.*);

`default_nettype wire
